@@ sv/rdc_pkg.sv @@
// Shared sizes and radix limits for the radix digit converter.
package rdc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VALUE_BITS  = 32;

    localparam int IN_W    = 32;
    localparam int DIGIT_W = 4;
    localparam int RADIX_W = 5;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W  = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

endpackage

@@ sv/rdc_if.sv @@
// Valid/ready channel interfaces for the value input and the digit output.
interface rdc_value_if import rdc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rdc_digit_if import rdc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last;

    modport source (output valid, output digit, output last, input ready);
    modport sink   (input valid, input digit, input last, output ready);
endinterface

@@ sv/radix_digit_converter.sv @@
// Radix digit converter: repeated division by a configured radix, digits out MSD first.
//
//  channel    dir   payload               transfer when
//  value_ch   in    value[31:0]           valid & ready
//  digit_ch   out   digit[3:0], last      valid & ready
//  cfg        in    cfg_wdata[4:0]        cfg_we (saturated to 2..16)
//
// One bit-serial restoring divider is reused for every digit: an item is accepted,
// divided once per digit, and its digits are then popped from the stack (read, present).
// Worst case is a value with 32 binary digits.
// value_ch.ready is high only while idle; a stalled digit holds the sequencer.
// rst_n is asynchronous; the radix resets to 2, the stack needs no clearing.
module radix_digit_converter
    import rdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [RADIX_W-1:0] cfg_wdata,
    rdc_value_if.sink          value_ch,
    rdc_digit_if.source        digit_ch
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_POP,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [RADIX_W-1:0]      radix_reg, radix_next;
    logic [VALUE_BITS-1:0]   quo_reg, quo_next;
    logic [RADIX_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SP_W-1:0]         sp_reg, sp_next;
    logic                    last_reg, last_next;

    // digit stack
    logic [DIGIT_W-1:0]      stack_mem [STACK_DEPTH];
    logic [DIGIT_W-1:0]      rd_data_reg;
    logic                    push_en;
    logic                    pop_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;

    // shared divider step
    logic [RADIX_W:0]        shifted;
    logic [RADIX_W:0]        diff;
    logic                    q_bit;
    logic [RADIX_W-1:0]      rem_step;
    logic [VALUE_BITS-1:0]   quo_step;

    assign shifted  = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff     = shifted - {1'b0, radix_reg};
    assign q_bit    = (shifted >= {1'b0, radix_reg});
    assign rem_step = q_bit ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
    assign quo_step = {quo_reg[VALUE_BITS-2:0], q_bit};

    assign wr_addr = sp_reg[ADDR_W-1:0];
    assign rd_addr = ADDR_W'(sp_reg - SP_W'(1));

    assign value_ch.ready = (state_reg == ST_IDLE);
    assign digit_ch.valid = (state_reg == ST_OUT);
    assign digit_ch.digit = rd_data_reg;
    assign digit_ch.last  = last_reg;

    always_comb
    begin
        state_next = state_reg;
        radix_next = radix_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        sp_next    = sp_reg;
        last_next  = last_reg;
        push_en    = 1'b0;
        pop_en     = 1'b0;

        // the user must change radix only while idle; there is no interlock, the block does not enforce it
        if (cfg_we)
        begin
            if (cfg_wdata < RADIX_MIN)
            begin
                radix_next = RADIX_MIN;
            end
            else if (cfg_wdata > RADIX_MAX)
            begin
                radix_next = RADIX_MAX;
            end
            else
            begin
                radix_next = cfg_wdata;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (value_ch.valid)
                begin
                    quo_next   = VALUE_BITS'(value_ch.value);
                    rem_next   = '0;
                    cnt_next   = CNT_W'(VALUE_BITS - 1);
                    sp_next    = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    // division done: push remainder, drop it once the stack is full
                    if (sp_reg < SP_W'(STACK_DEPTH))
                    begin
                        push_en = 1'b1;
                        sp_next = sp_reg + SP_W'(1);
                    end
                    rem_next = '0;
                    cnt_next = CNT_W'(VALUE_BITS - 1);
                    if (quo_step == '0)
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                pop_en     = 1'b1;
                sp_next    = sp_reg - SP_W'(1);
                last_next  = (sp_reg == SP_W'(1));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (digit_ch.ready)
                begin
                    state_next = last_reg ? ST_IDLE : ST_POP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            radix_reg <= RADIX_MIN;
            quo_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            sp_reg    <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            radix_reg <= radix_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            sp_reg    <= sp_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[wr_addr] <= rem_step[DIGIT_W-1:0];
        end
        if (pop_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX))
        else $error("radix register out of range");

    a_no_accept_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        digit_ch.valid |-> !value_ch.ready)
        else $error("input ready while a digit is pending");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_ch.valid && digit_ch.ready && digit_ch.last) |=> value_ch.ready)
        else $error("not idle after final digit transfer");

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> (sp_reg != '0))
        else $error("pop from empty stack");
`endif

endmodule
